FILE: rtl/bup_pkg.sv
package bup_pkg;

   // Operation codes carried in the request beat.
   typedef enum logic [1:0] {
      OP_START_BLOCK = 2'd0,
      OP_DATA_BYTE   = 2'd1,
      OP_START_EXEC  = 2'd2,
      OP_SAMPLE      = 2'd3
   } op_type;

   // Handshake phases, one-hot.
   typedef enum logic [5:0] {
      PH_BOOT  = 6'b000001,
      PH_IDLE  = 6'b000010,
      PH_KICK  = 6'b000100,
      PH_READY = 6'b001000,
      PH_BYTE  = 6'b010000,
      PH_EXEC  = 6'b100000
   } phase_type;

   // Encoded phase as reported on the response.
   localparam logic [2:0] PHASE_CODE_BOOT  = 3'd0;
   localparam logic [2:0] PHASE_CODE_IDLE  = 3'd1;
   localparam logic [2:0] PHASE_CODE_KICK  = 3'd2;
   localparam logic [2:0] PHASE_CODE_READY = 3'd3;
   localparam logic [2:0] PHASE_CODE_BYTE  = 3'd4;
   localparam logic [2:0] PHASE_CODE_EXEC  = 3'd5;

   localparam logic [7:0] BOOT_SIG_A  = 8'hAA;
   localparam logic [7:0] BOOT_SIG_B  = 8'hBB;
   localparam logic [7:0] KICK_OFFSET = 8'h22;

   typedef struct packed {
      op_type      operation;
      logic [15:0] target_address;
      logic [15:0] byte_count;
      logic [7:0]  data_byte;
      logic [7:0]  port0_sample;
   } req_type;

   typedef struct packed {
      logic        addr_write_en;
      logic [15:0] addr_write_value;
      logic        port1_write_en;
      logic [7:0]  port1_write_value;
      logic        port0_write_en;
      logic [7:0]  port0_write_value;
      logic        accepted;
      logic        echo_matched;
      logic        block_done;
      logic [2:0]  phase_now;
   } rsp_type;

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      code = PHASE_CODE_BOOT;
      case (ph)
         PH_BOOT:  code = PHASE_CODE_BOOT;
         PH_IDLE:  code = PHASE_CODE_IDLE;
         PH_KICK:  code = PHASE_CODE_KICK;
         PH_READY: code = PHASE_CODE_READY;
         PH_BYTE:  code = PHASE_CODE_BYTE;
         PH_EXEC:  code = PHASE_CODE_EXEC;
         default:  code = PHASE_CODE_BOOT;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/boot_upload_handshake_core.sv
// Host side of a mailbox boot upload handshake. Each request beat (a start-block,
// a data byte, a start-execute or a sample of the partner's port 0) produces exactly
// one response beat that says which port writes to make, whether the beat was legal
// in the current phase, whether an awaited echo was seen and which phase follows.
// One request beat is taken every clock cycle while request stall is low: the phase
// machine, the kick adder and the echo compare are combinational between the state
// registers and the output stage, so each response is registered in the response or skid register.
// A two-entry output stage (response register plus skid register) lets the block take
// a request while a finished response is still stalled; request stall rises only
// when both entries hold responses that have not been taken.
module boot_upload_handshake_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bup_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bup_pkg::rsp_type  rsp_data
);
   import bup_pkg::*;

   // Handshake state.
   phase_type   phase_ff, phase_in;
   logic [7:0]  awaited_echo_ff, awaited_echo_in;
   logic [15:0] byte_index_ff, byte_index_in;
   logic [15:0] block_length_ff, block_length_in;

   // Output stage.
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   logic    req_take;
   logic    rsp_take;
   rsp_type result;
   logic [7:0]  kick;
   logic [15:0] index_next;
   phase_type   phase_after;

   // A request is taken whenever the skid entry is free.
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   assign kick       = req_data.port0_sample + KICK_OFFSET;
   assign index_next = byte_index_ff + 16'd1;

   // Phase machine: decide the writes for this beat and the next state.
   // Illegal beats leave the state alone and report every write enable low.
   always_comb begin
      result          = '0;
      phase_after     = phase_ff;
      awaited_echo_in = awaited_echo_ff;
      byte_index_in   = byte_index_ff;
      block_length_in = block_length_ff;

      case (req_data.operation)
         OP_START_BLOCK: begin
            if (phase_ff == PH_IDLE && req_data.byte_count != 16'd0) begin
               result.addr_write_en     = 1'b1;
               result.addr_write_value  = req_data.target_address;
               result.port1_write_en    = 1'b1;
               result.port0_write_en    = 1'b1;
               result.accepted          = 1'b1;
               // A block kick must never be zero, since zero is the first index.
               if (kick == 8'd0) begin
                  result.port1_write_value = 8'd1;
                  result.port0_write_value = 8'd1;
                  awaited_echo_in          = 8'd1;
               end else begin
                  result.port1_write_value = kick;
                  result.port0_write_value = kick;
                  awaited_echo_in          = kick;
               end
               block_length_in = req_data.byte_count;
               byte_index_in   = 16'd0;
               phase_after     = PH_KICK;
            end
         end
         OP_DATA_BYTE: begin
            if (phase_ff == PH_READY) begin
               result.port1_write_en    = 1'b1;
               result.port1_write_value = req_data.data_byte;
               result.port0_write_en    = 1'b1;
               result.port0_write_value = byte_index_ff[7:0];
               result.accepted          = 1'b1;
               awaited_echo_in          = byte_index_ff[7:0];
               phase_after              = PH_BYTE;
            end
         end
         OP_START_EXEC: begin
            if (phase_ff == PH_IDLE) begin
               result.addr_write_en     = 1'b1;
               result.addr_write_value  = req_data.target_address;
               result.port1_write_en    = 1'b1;
               result.port0_write_en    = 1'b1;
               result.port0_write_value = kick;
               result.accepted          = 1'b1;
               awaited_echo_in          = kick;
               phase_after              = PH_EXEC;
            end
         end
         OP_SAMPLE: begin
            if (phase_ff == PH_BOOT) begin
               result.accepted = 1'b1;
               if (req_data.port0_sample == BOOT_SIG_A ||
                   req_data.port0_sample == BOOT_SIG_B) begin
                  result.echo_matched = 1'b1;
                  phase_after         = PH_IDLE;
               end
            end else if (phase_ff == PH_KICK || phase_ff == PH_BYTE ||
                         phase_ff == PH_EXEC) begin
               result.accepted = 1'b1;
               if (req_data.port0_sample == awaited_echo_ff) begin
                  result.echo_matched = 1'b1;
                  if (phase_ff == PH_KICK) begin
                     phase_after = PH_READY;
                  end else if (phase_ff == PH_EXEC) begin
                     phase_after = PH_IDLE;
                  end else begin
                     // Byte echo seen: advance and check for the end of the block.
                     byte_index_in = index_next;
                     if (index_next == block_length_ff) begin
                        result.block_done = 1'b1;
                        phase_after       = PH_IDLE;
                     end else begin
                        phase_after = PH_READY;
                     end
                  end
               end
            end
         end
         default: begin
            result = '0;
         end
      endcase

      result.phase_now = phase_code(phase_after);
      phase_in         = req_take ? phase_after : phase_ff;
      if (!req_take) begin
         awaited_echo_in = awaited_echo_ff;
         byte_index_in   = byte_index_ff;
         block_length_in = block_length_ff;
      end
   end

   // Output stage: the response register feeds the port, the skid register catches
   // a beat that arrives while the response register is stalled.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_take;
            out_data_in  = result;
         end
      end else if (req_take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_BOOT;
         awaited_echo_ff <= 8'd0;
         byte_index_ff   <= 16'd0;
         block_length_ff <= 16'd0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         awaited_echo_ff <= awaited_echo_in;
         byte_index_ff   <= byte_index_in;
         block_length_ff <= block_length_in;
         out_valid_ff    <= out_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   // The skid entry is only ever filled behind a held response.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without a response entry");

   // An echo can only be reported on a legal beat.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.echo_matched) |-> rsp_data.accepted)
      else $error("echo matched on a rejected beat");

   // Finishing a block always returns to idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.block_done) |-> (rsp_data.phase_now == PHASE_CODE_IDLE))
      else $error("block done without returning to idle");

   // A rejected beat makes no port writes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.accepted) |->
         (!rsp_data.addr_write_en && !rsp_data.port1_write_en && !rsp_data.port0_write_en))
      else $error("port write on a rejected beat");
`endif

endmodule

FILE: sim/tb_boot_upload_handshake_core.sv
`timescale 1ns / 1ps

module tb_boot_upload_handshake_core;
   import bup_pkg::*;

   // Upper bound on the run in clock cycles. The slowest correct run takes roughly
   // 1800 request beats, each with a drawn idle gap on the request side plus a drawn
   // stall on the response side, so this limit leaves a wide margin.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int DRAIN_CYCLES  = 10;

   // Tracks the handshake state of the partner link and holds the port writes
   // expected for every request beat that the block has taken.
   class upload_scoreboard;
      logic [2:0]  cur_phase;
      logic [7:0]  awaited_echo;
      logic [15:0] byte_index;
      logic [15:0] block_length;
      rsp_type     pending_writes[$];
      int          errors;

      function new();
         cur_phase    = PHASE_CODE_BOOT;
         awaited_echo = 8'h00;
         byte_index   = 16'h0000;
         block_length = 16'h0000;
         errors       = 0;
      endfunction

      // Works out the response to one taken request beat, queues it and advances
      // the handshake state. Returns 1 when the beat is legal in the current phase.
      function bit note_request(req_type r);
         rsp_type    e;
         logic [7:0] kick;
         e    = '0;
         kick = r.port0_sample + KICK_OFFSET;
         case (r.operation)
            OP_START_BLOCK: begin
               if (cur_phase == PHASE_CODE_IDLE && r.byte_count != 16'h0000) begin
                  // A block kick may never be zero, since zero is a valid index echo.
                  if (kick == 8'h00)
                     kick = 8'h01;
                  e.addr_write_en     = 1'b1;
                  e.addr_write_value  = r.target_address;
                  e.port1_write_en    = 1'b1;
                  e.port1_write_value = kick;
                  e.port0_write_en    = 1'b1;
                  e.port0_write_value = kick;
                  e.accepted          = 1'b1;
                  awaited_echo        = kick;
                  block_length        = r.byte_count;
                  byte_index          = 16'h0000;
                  cur_phase           = PHASE_CODE_KICK;
               end
            end
            OP_DATA_BYTE: begin
               if (cur_phase == PHASE_CODE_READY) begin
                  e.port1_write_en    = 1'b1;
                  e.port1_write_value = r.data_byte;
                  e.port0_write_en    = 1'b1;
                  e.port0_write_value = byte_index[7:0];
                  e.accepted          = 1'b1;
                  awaited_echo        = byte_index[7:0];
                  cur_phase           = PHASE_CODE_BYTE;
               end
            end
            OP_START_EXEC: begin
               if (cur_phase == PHASE_CODE_IDLE) begin
                  e.addr_write_en     = 1'b1;
                  e.addr_write_value  = r.target_address;
                  e.port1_write_en    = 1'b1;
                  e.port1_write_value = 8'h00;
                  e.port0_write_en    = 1'b1;
                  e.port0_write_value = kick;
                  e.accepted          = 1'b1;
                  awaited_echo        = kick;
                  cur_phase           = PHASE_CODE_EXEC;
               end
            end
            OP_SAMPLE: begin
               if (cur_phase == PHASE_CODE_BOOT) begin
                  e.accepted = 1'b1;
                  if (r.port0_sample == BOOT_SIG_A || r.port0_sample == BOOT_SIG_B) begin
                     e.echo_matched = 1'b1;
                     cur_phase      = PHASE_CODE_IDLE;
                  end
               end else if (cur_phase == PHASE_CODE_KICK || cur_phase == PHASE_CODE_BYTE ||
                            cur_phase == PHASE_CODE_EXEC) begin
                  e.accepted = 1'b1;
                  if (r.port0_sample == awaited_echo) begin
                     e.echo_matched = 1'b1;
                     if (cur_phase == PHASE_CODE_KICK) begin
                        cur_phase = PHASE_CODE_READY;
                     end else if (cur_phase == PHASE_CODE_EXEC) begin
                        cur_phase = PHASE_CODE_IDLE;
                     end else begin
                        byte_index = byte_index + 16'h0001;
                        if (byte_index == block_length) begin
                           e.block_done = 1'b1;
                           cur_phase    = PHASE_CODE_IDLE;
                        end else begin
                           cur_phase = PHASE_CODE_READY;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
         e.phase_now = cur_phase;
         pending_writes.push_back(e);
         return e.accepted;
      endfunction

      function void compare_field(string field, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      // Compares one response beat with the oldest expectation.
      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_writes.size() == 0) begin
            $display("%0t: response beat expected none actual %0h", $time, got);
            errors++;
         end else begin
            want = pending_writes.pop_front();
            compare_field("addr_write_en",     want.addr_write_en,     got.addr_write_en);
            compare_field("addr_write_value",  want.addr_write_value,  got.addr_write_value);
            compare_field("port1_write_en",    want.port1_write_en,    got.port1_write_en);
            compare_field("port1_write_value", want.port1_write_value, got.port1_write_value);
            compare_field("port0_write_en",    want.port0_write_en,    got.port0_write_en);
            compare_field("port0_write_value", want.port0_write_value, got.port0_write_value);
            compare_field("accepted",          want.accepted,          got.accepted);
            compare_field("echo_matched",      want.echo_matched,      got.echo_matched);
            compare_field("block_done",        want.block_done,        got.block_done);
            compare_field("phase_now",         want.phase_now,         got.phase_now);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   upload_scoreboard link = new();

   int  cycle_count    = 0;
   int  req_beat_count = 0;
   int  rsp_beat_count = 0;
   bit  req_gaps_on    = 1'b0;
   bit  rsp_gaps_on    = 1'b0;
   bit  wrap_block_sent = 1'b0;

   boot_upload_handshake_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog. A hung handshake or a lost response beat ends the run here.
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Response monitor. Signals are read right after the rising edge, before any
   // nonblocking update of that edge lands, so they hold the values the block saw
   // at the edge. A beat moves when valid is high and stall is low.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            link.check_response(rsp_data);
      end
   end

   // Response stall. Before each beat the receiver may hold stall high for a randomly
   // drawn hold, then drops it and waits for a beat. Every 40 beats it decides anew
   // whether to stall at all, so long stretches run back to back as well.
   initial begin
      int hold;
      forever begin
         if (rsp_beat_count % 40 == 0)
            rsp_gaps_on = ($urandom_range(0, 2) != 0);
         hold = rsp_gaps_on ? $urandom_range(0, 7) : 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do
            @(posedge clock);
         while (reset || rsp_valid !== 1'b1);
         rsp_beat_count++;
      end
   end

   // Sends one request beat. The idle gap is drawn first; valid only drops when
   // there is a gap, so back-to-back beats never see valid lowered and raised in
   // the same time step. The beat is noted at the edge that takes it.
   task automatic drive_beat(input req_type r);
      int gap;
      if (req_beat_count % 50 == 0)
         req_gaps_on = ($urandom_range(0, 2) != 0);
      gap = req_gaps_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      void'(link.note_request(r));
      req_beat_count++;
   endtask

   task automatic send(input op_type op, input logic [15:0] addr, input logic [15:0] count,
                       input logic [7:0] data, input logic [7:0] sample);
      req_type r;
      r.operation      = op;
      r.target_address = addr;
      r.byte_count     = count;
      r.data_byte      = data;
      r.port0_sample   = sample;
      drive_beat(r);
   endtask

   // Builds the next random request beat from the tracked handshake phase. Most
   // beats are what a well-behaved host would send next, with random content;
   // one in ten is pure noise, and echoes are sometimes wrong on purpose.
   function automatic req_type next_request();
      req_type     r;
      logic [63:0] fill;
      fill = {$urandom(), $urandom()};
      r    = fill[$bits(req_type)-1:0];
      if ($urandom_range(0, 9) == 0)
         return r;
      case (link.cur_phase)
         PHASE_CODE_BOOT: begin
            r.operation = OP_SAMPLE;
            if ($urandom_range(0, 1) == 0)
               r.port0_sample = $urandom_range(0, 1) ? BOOT_SIG_A : BOOT_SIG_B;
         end
         PHASE_CODE_IDLE: begin
            if ($urandom_range(0, 3) == 0) begin
               r.operation = OP_START_EXEC;
            end else begin
               r.operation = OP_START_BLOCK;
               // The first block runs past 256 bytes so the 8-bit index wraps.
               if (!wrap_block_sent) begin
                  r.byte_count    = 16'($urandom_range(258, 300));
                  wrap_block_sent = 1'b1;
               end else if ($urandom_range(0, 19) == 0) begin
                  r.byte_count = 16'h0000;
               end else if ($urandom_range(0, 9) == 0) begin
                  r.byte_count = 16'($urandom_range(1, 40));
               end else begin
                  r.byte_count = 16'($urandom_range(1, 8));
               end
            end
         end
         PHASE_CODE_READY: begin
            r.operation = OP_DATA_BYTE;
         end
         default: begin
            // Kick, byte or execute acknowledge: mostly the right echo.
            r.operation = OP_SAMPLE;
            if ($urandom_range(0, 3) != 0)
               r.port0_sample = link.awaited_echo;
         end
      endcase
      return r;
   endfunction

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Boot: a non-signature sample, wrong-phase beats, then the
      // signature.
      send(OP_SAMPLE,      16'h0000, 16'h0000, 8'h00, 8'h00);
      send(OP_DATA_BYTE,   16'h1234, 16'h0001, 8'h5A, 8'hAA);
      send(OP_START_BLOCK, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
      send(OP_START_EXEC,  16'hFFFF, 16'h0000, 8'h00, 8'hBB);
      send(OP_SAMPLE,      16'h0000, 16'h0000, 8'h00, BOOT_SIG_A);
      // Idle: a sample and a data byte are out of phase, and a zero count is refused.
      send(OP_SAMPLE,      16'h0000, 16'h0000, 8'h00, 8'h55);
      send(OP_DATA_BYTE,   16'h0000, 16'h0000, 8'hFF, 8'h00);
      send(OP_START_BLOCK, 16'hABCD, 16'h0000, 8'h00, 8'h10);
      // One-byte block whose kick wraps to zero and is forced to one.
      send(OP_START_BLOCK, 16'hFFFF, 16'h0001, 8'h00, 8'hDE);
      send(OP_SAMPLE,      16'h0000, 16'h0000, 8'h00, 8'h00);
      send(OP_START_EXEC,  16'h0000, 16'h0000, 8'h00, 8'h00);
      send(OP_SAMPLE,      16'h0000, 16'h0000, 8'h00, 8'h01);
      send(OP_SAMPLE,      16'h0000, 16'h0000, 8'h00, 8'h01);
      send(OP_START_BLOCK, 16'h0000, 16'h0001, 8'h00, 8'h00);
      send(OP_DATA_BYTE,   16'h0000, 16'h0000, 8'hFF, 8'h00);
      send(OP_DATA_BYTE,   16'h0000, 16'h0000, 8'h00, 8'h00);
      send(OP_SAMPLE,      16'h0000, 16'h0000, 8'h00, 8'h00);
      // Execute whose kick wraps to zero and stays zero.
      send(OP_START_EXEC,  16'h0000, 16'hFFFF, 8'hFF, 8'hDE);
      send(OP_SAMPLE,      16'h0000, 16'h0000, 8'h00, 8'hFF);
      send(OP_SAMPLE,      16'h0000, 16'h0000, 8'h00, 8'h00);
      // Two-byte block ending on a done flag.
      send(OP_START_BLOCK, 16'h8000, 16'h0002, 8'h00, 8'hFF);
      send(OP_SAMPLE,      16'h0000, 16'h0000, 8'h00, 8'h21);
      send(OP_DATA_BYTE,   16'h0000, 16'h0000, 8'h80, 8'h00);
      send(OP_SAMPLE,      16'h0000, 16'h0000, 8'h00, 8'h00);
      send(OP_DATA_BYTE,   16'h0000, 16'h0000, 8'h7F, 8'h00);
      send(OP_SAMPLE,      16'h0000, 16'h0000, 8'h00, 8'h01);

      // Random part: a fixed number of request beats, legal or not.
      repeat (RANDOM_ITEMS)
         drive_beat(next_request());
      req_valid <= 1'b0;

      // Let every outstanding response arrive, then keep watching for stray beats.
      // The watchdog covers a response that never comes.
      while (link.pending_writes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (link.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
